/* design/sist_pkg.sv */
// shared types, codes and constants of the sorted integer set table
package sist_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int KIND_W       = 2;
  localparam int COUNT_OUT_W  = 5;
  localparam int IN_DATA_W    = 32;
  localparam int OUT_DATA_W   = 40;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD     = 2'd0,
    KIND_REMOVE  = 2'd1,
    KIND_MEMBER  = 2'd2,
    KIND_EXTRACT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    RD_MID,
    RD_BELOW,
    RD_ABOVE,
    RD_FIRST
  } rd_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BS_RD,
    ST_BS_CMP,
    ST_DECIDE,
    ST_INS_CHK,
    ST_INS_WR,
    ST_DEL_CHK,
    ST_DEL_WR,
    ST_X_RD,
    ST_X_CAP,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    bs_step;
    logic    ins_init;
    logic    ins_step;
    logic    ins_new;
    logic    del_init;
    logic    del_step;
    logic    cnt_dec;
    logic    ext_cap;
    logic    succ_set;
    logic    full_set;
    logic    res_load;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  bs_done;
    logic  found;
    logic  full;
    logic  empty;
    logic  ins_more;
    logic  del_more;
    logic  out_free;
  } dp_sts_t;

endpackage

/* design/sorted_integer_set_table_unit.sv */
// top level of the sorted integer set table: controller and datapath
//
//  channel  dir  ports                           beat contents
//  in_      in   in_tvalid/in_tready             tuser kind, tdata value
//  out_     out  out_tvalid/out_tready           tdata success .. is_empty
//
// one operation at a time; the binary search over the entry memory reads a
// probe and then compares it (one read port), and the shift moves entries one
// at a time with a read step and a write step each; probes at most
// ceil(log2(count+1)); extract skips the search, reads the first entry and
// shifts the rest down, or goes straight to the result on an empty table
// reset clears the count and the result valid flag; entry memory needs no clearing
// a new beat is taken while the previous result still waits at the output
// a stalled output holds the controller at its result step only
module sorted_integer_set_table_unit import sist_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // value[31:0]
  input  logic [KIND_W-1:0]     in_tuser,   // kind[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // success, full_flag, extracted_value[31:0],
                                            // element_count[4:0], is_empty
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  sist_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sist_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* design/sist_dpath.sv */
// datapath: entry memory, count, search bounds, shift index and result register
module sist_dpath import sist_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // value
  input  logic [KIND_W-1:0]     in_tuser,   // kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // success, full_flag, extracted_value, element_count, is_empty
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [VALUE_W-1:0] rdata_r;

  logic [CW-1:0]      count_r;
  logic [CW-1:0]      lo_r, hi_r, idx_r;
  kind_t              op_kind_r;
  logic [VALUE_W-1:0] op_value_r;
  logic               found_r, succ_r, full_r;
  logic [VALUE_W-1:0] ext_r;

  logic                   out_valid_r;
  logic                   out_success_r, out_full_r, out_empty_r;
  logic [VALUE_W-1:0]     out_ext_r;
  logic [COUNT_OUT_W-1:0] out_count_r;

  logic [CW:0]             mid_sum;
  logic [CW-1:0]           mid;
  logic [CW-1:0]           idx_m1, idx_p1;
  logic [AW-1:0]           rd_addr, wr_addr;
  logic [VALUE_W-1:0]      wr_data;
  logic                    wr_en;
  logic [CW+COUNT_OUT_W-1:0] count_wide;

  assign mid_sum    = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid        = mid_sum[CW:1];
  assign idx_m1     = idx_r - 1'b1;
  assign idx_p1     = idx_r + 1'b1;
  assign count_wide = {{COUNT_OUT_W{1'b0}}, count_r};

  always_comb begin
    case (cmd.rd_sel)
      RD_MID:   rd_addr = mid[AW-1:0];
      RD_BELOW: rd_addr = idx_m1[AW-1:0];
      RD_ABOVE: rd_addr = idx_p1[AW-1:0];
      default:  rd_addr = '0;
    endcase
  end

  assign wr_en   = cmd.ins_step | cmd.del_step | cmd.ins_new;
  assign wr_addr = cmd.ins_new ? lo_r[AW-1:0] : idx_r[AW-1:0];
  assign wr_data = cmd.ins_new ? op_value_r : rdata_r;

  // entry memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.ins_new) begin
      count_r <= count_r + 1'b1;
    end else if (cmd.cnt_dec) begin
      count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_kind_r  <= kind_t'(in_tuser);
      op_value_r <= in_tdata[VALUE_W-1:0];
      lo_r       <= '0;
      hi_r       <= count_r;
      found_r    <= 1'b0;
      succ_r     <= 1'b0;
      full_r     <= 1'b0;
      ext_r      <= '0;
    end else begin
      if (cmd.bs_step) begin
        if ($signed(rdata_r) < $signed(op_value_r)) begin
          lo_r <= mid + 1'b1;
        end else begin
          hi_r <= mid;
        end
        if (rdata_r == op_value_r) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.succ_set) begin
        succ_r <= 1'b1;
      end
      if (cmd.full_set) begin
        full_r <= 1'b1;
      end
      if (cmd.ext_cap) begin
        ext_r <= rdata_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_init) begin
      idx_r <= count_r;
    end else if (cmd.del_init) begin
      idx_r <= lo_r;
    end else if (cmd.ins_step) begin
      idx_r <= idx_m1;
    end else if (cmd.del_step) begin
      idx_r <= idx_p1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_success_r <= succ_r;
      out_full_r    <= full_r;
      out_ext_r     <= ext_r;
      out_count_r   <= count_wide[COUNT_OUT_W-1:0];
      out_empty_r   <= (count_r == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_empty_r, out_count_r, out_ext_r, out_full_r, out_success_r};

  assign sts.kind     = op_kind_r;
  assign sts.bs_done  = (lo_r == hi_r);
  assign sts.found    = found_r;
  assign sts.full     = (count_r == CW'(CAPACITY));
  assign sts.empty    = (count_r == '0);
  assign sts.ins_more = (idx_r > lo_r);
  assign sts.del_more = ({1'b0, idx_r} + 1'b1) < {1'b0, count_r};
  assign sts.out_free = !out_valid_r || out_tready;

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(count_r) |->
      (count_r == $past(count_r) + 1'b1) || (count_r == $past(count_r) - 1'b1))
    else $error("entry count moved by more than one");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_full_r |-> !out_success_r)
    else $error("refused add reported as success");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_success_r |-> out_ext_r == '0)
    else $error("extracted value set on a failed operation");

endmodule

/* design/sist_ctrl.sv */
// controller: sequences search, shift and result phases of one operation
module sist_ctrl import sist_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_BS_RD;
      end
      ST_BS_RD: begin
        if (sts.kind == KIND_EXTRACT) state_nxt = ST_X_RD;
        else if (sts.bs_done)         state_nxt = ST_DECIDE;
        else                          state_nxt = ST_BS_CMP;
      end
      ST_BS_CMP: state_nxt = ST_BS_RD;
      ST_DECIDE: begin
        unique case (sts.kind)
          KIND_ADD:    state_nxt = (sts.found || sts.full) ? ST_RESULT : ST_INS_CHK;
          KIND_REMOVE: state_nxt = sts.found ? ST_DEL_CHK : ST_RESULT;
          default:     state_nxt = ST_RESULT;
        endcase
      end
      ST_INS_CHK: state_nxt = sts.ins_more ? ST_INS_WR : ST_RESULT;
      ST_INS_WR:  state_nxt = ST_INS_CHK;
      ST_DEL_CHK: state_nxt = sts.del_more ? ST_DEL_WR : ST_RESULT;
      ST_DEL_WR:  state_nxt = ST_DEL_CHK;
      ST_X_RD:    state_nxt = sts.empty ? ST_RESULT : ST_X_CAP;
      ST_X_CAP:   state_nxt = ST_DEL_CHK;
      ST_RESULT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.rd_sel = RD_MID;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_BS_RD: begin
        if (sts.kind != KIND_EXTRACT && !sts.bs_done) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_MID;
        end
      end
      ST_BS_CMP: cmd.bs_step = 1'b1;
      ST_DECIDE: begin
        unique case (sts.kind)
          KIND_ADD: begin
            if (!sts.found && sts.full) cmd.full_set = 1'b1;
            if (!sts.found && !sts.full) cmd.ins_init = 1'b1;
          end
          KIND_REMOVE: begin
            cmd.succ_set = sts.found;
            cmd.del_init = sts.found;
          end
          KIND_MEMBER: cmd.succ_set = sts.found;
          default: ;
        endcase
      end
      ST_INS_CHK: begin
        if (sts.ins_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_BELOW;
        end else begin
          cmd.ins_new  = 1'b1;
          cmd.succ_set = 1'b1;
        end
      end
      ST_INS_WR: cmd.ins_step = 1'b1;
      ST_DEL_CHK: begin
        if (sts.del_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_ABOVE;
        end else begin
          cmd.cnt_dec = 1'b1;
        end
      end
      ST_DEL_WR: cmd.del_step = 1'b1;
      ST_X_RD: begin
        if (!sts.empty) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_FIRST;
        end
      end
      ST_X_CAP: begin
        cmd.ext_cap  = 1'b1;
        cmd.succ_set = 1'b1;
        cmd.del_init = 1'b1;
      end
      ST_RESULT: cmd.res_load = sts.out_free;
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_new |-> !cmd.cnt_dec && !cmd.del_step)
    else $error("insert and delete in the same cycle");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_BS_RD)
    else $error("operation accepted without starting the search");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |=> state_r == ST_IDLE)
    else $error("result loaded without returning to idle");

endmodule
